// File: src/page_hotness_tracker_tiering_top_macros.svh
// assertion macros for the page hotness tracker
// no dependencies
`ifndef PAGE_HOTNESS_TRACKER_TIERING_TOP_MACROS_SVH
`define PAGE_HOTNESS_TRACKER_TIERING_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define PHT_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pht check failed");
// next-cycle implication
`define PHT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pht check failed");
`endif

// File: src/pht_pkg.sv
// shared types and codes for the page hotness tracker
// no dependencies
`default_nettype none
package pht_pkg;
  localparam int PAGE_W = 52;
  localparam int TOTAL_W = 40;
  localparam int PCNT_W = 9;
  localparam logic [2:0] OP_MISS = 3'd0;
  localparam logic [2:0] OP_CRIT = 3'd1;
  localparam logic [2:0] OP_ACCESS = 3'd2;
  localparam logic [2:0] OP_ALLOC = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;
  localparam logic [1:0] ST_RATIO0 = 2'd3;
  localparam logic [1:0] REG_RANK = 2'd0;
  localparam logic [1:0] REG_FAST = 2'd1;
  localparam logic [1:0] REG_SLOW = 2'd2;
  localparam int CFG_W = 16;

  typedef struct packed {
    logic [2:0] opcode;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic is_fast;
    logic [PCNT_W-1:0] fast_pages;
    logic [PCNT_W-1:0] slow_pages;
    logic [TOTAL_W-1:0] fast_access_total;
    logic [TOTAL_W-1:0] slow_access_total;
  } rsp_t;
endpackage
`default_nettype wire

// File: src/pht_if.sv
// valid/ready channel carrying a request or result payload
// depends on pht_pkg
`default_nettype none
interface pht_req_if;
  logic valid;
  logic ready;
  pht_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pht_rsp_if;
  logic valid;
  logic ready;
  pht_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/pht_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameter
`default_nettype none
module pht_div #(
  parameter int W = 32
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [W-1:0] num,
  input wire logic [W-1:0] den,
  output logic done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem;
  logic [W-1:0] q;
  logic [W-1:0] d;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W:0] trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        q <= num;
        d <= den;
        cnt <= CW'(W);
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], q[W-1]};
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/page_hotness_tracker_tiering_top.sv
// events and queries scan the used entries before giving their result;
// allocate divides, then ranks the entries pairwise over one read port
// throughput: one request at a time; the next is taken once the result register is free
// reset: synchronous, clears entry count and registers; tables and marks need no clearing
// because each entry is written in full when created and only slots below the count are read
`default_nettype none
module page_hotness_tracker_tiering_top #(
  parameter int MAX_PAGES = 256,
  parameter int COUNT_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  pht_req_if.sink req,
  pht_rsp_if.source rsp,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [pht_pkg::CFG_W-1:0] cfg_data
);
  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NW = $clog2(MAX_PAGES + 1);
  localparam int DW = NW + 17;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_SCAN = 9'b000000010, S_UPD = 9'b000000100,
    S_DIV = 9'b000001000, S_RI = 9'b000010000, S_RJ = 9'b000100000,
    S_MARK = 9'b001000000, S_OUT = 9'b010000000, S_RD = 9'b100000000
  } state_t;
  state_t state;

  // entry stores
  logic [pht_pkg::PAGE_W-1:0] page_mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] miss_mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] crit_mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] acc_mem [MAX_PAGES];
  logic mark_mem [MAX_PAGES];
  logic [NW-1:0] used;

  logic rank_by_critical;
  logic [15:0] fast_share, slow_share;

  pht_pkg::req_t cur;
  pht_pkg::rsp_t res;
  logic rsp_valid;

  logic [AW-1:0] raddr, waddr, slot, slot_iss;
  logic [NW-1:0] idx, jdx, cnt_i;
  logic issued, rd_pend;
  logic [pht_pkg::PAGE_W-1:0] rd_page;
  logic [COUNT_BITS-1:0] rd_miss, rd_crit, rd_acc;
  logic rd_mark;
  logic we;
  logic [pht_pkg::PAGE_W-1:0] wpage;
  logic [COUNT_BITS-1:0] wmiss, wcrit, wacc;
  logic mwe, mwdata;
  logic [AW-1:0] mwaddr;
  logic found;
  logic hit_mark;

  // rank pass registers
  logic [COUNT_BITS-1:0] ki, acc_i;
  logic [pht_pkg::PAGE_W-1:0] pi;
  logic [NW-1:0] rank;
  logic [NW-1:0] nfast;
  logic [NW-1:0] cf, cs;
  logic [pht_pkg::TOTAL_W-1:0] tf, ts;

  logic div_start, div_done;
  logic [DW-1:0] div_q;
  logic [16:0] ssum;
  assign ssum = {1'b0, fast_share} + {1'b0, slow_share};

  pht_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(DW'(used) * DW'(fast_share)), .den(DW'(ssum)),
    .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      page_mem[waddr] <= wpage;
      miss_mem[waddr] <= wmiss;
      crit_mem[waddr] <= wcrit;
      acc_mem[waddr] <= wacc;
    end
    rd_page <= page_mem[raddr];
    rd_miss <= miss_mem[raddr];
    rd_crit <= crit_mem[raddr];
    rd_acc <= acc_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mwe) mark_mem[mwaddr] <= mwdata;
    rd_mark <= mark_mem[raddr];
  end

  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.data = res;

  function automatic logic [pht_pkg::TOTAL_W-1:0] sat_add(
    input logic [pht_pkg::TOTAL_W-1:0] a, input logic [COUNT_BITS-1:0] b);
    logic [pht_pkg::TOTAL_W+COUNT_BITS:0] s;
    s = (pht_pkg::TOTAL_W + COUNT_BITS + 1)'(a) + (pht_pkg::TOTAL_W + COUNT_BITS + 1)'(b);
    return (s > (pht_pkg::TOTAL_W + COUNT_BITS + 1)'({pht_pkg::TOTAL_W{1'b1}}))
      ? '1 : s[pht_pkg::TOTAL_W-1:0];
  endfunction

  logic [COUNT_BITS-1:0] kj;
  assign kj = rank_by_critical ? rd_crit : rd_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      used <= '0;
      rank_by_critical <= 1'b0;
      fast_share <= 16'd1;
      slow_share <= 16'd1;
      we <= 1'b0;
      mwe <= 1'b0;
      div_start <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pht_pkg::REG_RANK: rank_by_critical <= cfg_data[0];
          pht_pkg::REG_FAST: fast_share <= cfg_data;
          pht_pkg::REG_SLOW: slow_share <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          cur <= req.data;
          idx <= '0;
          raddr <= '0;
          issued <= 1'b0;
          rd_pend <= 1'b0;
          found <= 1'b0;
          if (req.data.opcode <= pht_pkg::OP_ACCESS || req.data.opcode == pht_pkg::OP_QUERY)
          begin
            res <= '0;
            state <= S_SCAN;
          end else if (req.data.opcode == pht_pkg::OP_ALLOC) begin
            if (used == '0) begin
              res <= '{status: pht_pkg::ST_NODATA, default: '0};
              state <= S_OUT;
            end else if (ssum == 17'd0) begin
              res <= '{status: pht_pkg::ST_RATIO0, default: '0};
              state <= S_OUT;
            end else begin
              res <= '0;
              div_start <= 1'b1;
              state <= S_DIV;
            end
          end else begin
            res <= '0;
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          // each read goes through raddr, then the rd_* registers; issued and rd_pend track it alongside
          if (rd_pend && rd_page == cur.page) begin
            found <= 1'b1;
            hit_mark <= rd_mark;
            wmiss <= rd_miss;
            wcrit <= rd_crit;
            wacc <= rd_acc;
            state <= S_UPD;
          end else begin
            rd_pend <= issued;
            slot <= slot_iss;
            if (idx < used) begin
              slot_iss <= idx[AW-1:0];
              raddr <= idx[AW-1:0];
              idx <= idx + 1'b1;
              issued <= 1'b1;
            end else begin
              issued <= 1'b0;
              if (!issued && !rd_pend) state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (cur.opcode == pht_pkg::OP_QUERY) begin
            res.is_fast <= found & hit_mark;
            state <= S_OUT;
          end else if (!found && used >= NW'(MAX_PAGES)) begin
            res.status <= pht_pkg::ST_FULL;
            state <= S_OUT;
          end else begin
            we <= 1'b1;
            wpage <= cur.page;
            if (found) begin
              waddr <= slot;
              if (cur.opcode == pht_pkg::OP_MISS && wmiss != CMAX) wmiss <= wmiss + 1'b1;
              if (cur.opcode == pht_pkg::OP_CRIT && wcrit != CMAX) wcrit <= wcrit + 1'b1;
              if (cur.opcode == pht_pkg::OP_ACCESS && wacc != CMAX) wacc <= wacc + 1'b1;
            end else begin
              waddr <= used[AW-1:0];
              mwe <= 1'b1;
              mwaddr <= used[AW-1:0];
              mwdata <= 1'b0;
              used <= used + 1'b1;
              wmiss <= COUNT_BITS'(cur.opcode == pht_pkg::OP_MISS);
              wcrit <= COUNT_BITS'(cur.opcode == pht_pkg::OP_CRIT);
              wacc <= COUNT_BITS'(cur.opcode == pht_pkg::OP_ACCESS);
            end
            state <= S_OUT;
          end
        end
        S_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            nfast <= div_q[NW-1:0];
            cnt_i <= '0;
            cf <= '0; cs <= '0; tf <= '0; ts <= '0;
            raddr <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          // wait for read of entry i
          mwe <= 1'b0;
          state <= S_RI;
        end
        S_RI: begin
          ki <= rank_by_critical ? rd_crit : rd_miss;
          pi <= rd_page;
          acc_i <= rd_acc;
          rank <= '0;
          jdx <= '0;
          raddr <= '0;
          issued <= 1'b0;
          rd_pend <= 1'b0;
          state <= S_RJ;
        end
        S_RJ: begin
          rd_pend <= issued;
          if (rd_pend && ((kj > ki) || (kj == ki && rd_page < pi)))
            rank <= rank + 1'b1;
          if (jdx < used) begin
            raddr <= jdx[AW-1:0];
            jdx <= jdx + 1'b1;
            issued <= 1'b1;
          end else begin
            issued <= 1'b0;
            if (!issued && !rd_pend) state <= S_MARK;
          end
        end
        S_MARK: begin
          mwe <= 1'b1;
          mwaddr <= cnt_i[AW-1:0];
          mwdata <= (rank < nfast);
          if (rank < nfast) begin
            cf <= cf + 1'b1;
            tf <= sat_add(tf, acc_i);
          end else begin
            cs <= cs + 1'b1;
            ts <= sat_add(ts, acc_i);
          end
          if (cnt_i + 1'b1 >= used) begin
            state <= S_OUT;
            res.fast_pages <= pht_pkg::PCNT_W'(rank < nfast ? cf + 1'b1 : cf);
            res.slow_pages <= pht_pkg::PCNT_W'(rank < nfast ? cs : cs + 1'b1);
            res.fast_access_total <= (rank < nfast) ? sat_add(tf, acc_i) : tf;
            res.slow_access_total <= (rank < nfast) ? ts : sat_add(ts, acc_i);
          end else begin
            cnt_i <= cnt_i + 1'b1;
            raddr <= cnt_i[AW-1:0] + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: begin
          rsp_valid <= 1'b1;
          we <= 1'b0;
          mwe <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "page_hotness_tracker_tiering_top_macros.svh"
  `PHT_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, used <= NW'(MAX_PAGES))
  `PHT_ASSERT_NEXT(a_out_valid, clk, rst, state == S_OUT, rsp_valid)
  `PHT_ASSERT_IMP(a_idle_rdy, clk, rst, req.ready, state == S_IDLE)
endmodule
`default_nettype wire
